// ----- src/cmsd_pkg.sv -----
// Package for the drift-corrected mean squared displacement block.
// Holds the sizes, payload structs and shared codes; no dependencies.
`default_nettype none

package cmsd_pkg;

  // Sizing of the position store and coordinate format.
  localparam int MAX_ATOMS  = 4096;
  localparam int COORD_BITS = 24;

  // Fixed field widths of the ports.
  localparam int POS_W   = 24;
  localparam int CFG_W   = 13;
  localparam int MSD_W   = 50;
  localparam int FRAME_W = 16;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Derived internal widths.
  localparam int IDX_W    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CNT_W    = IDX_W + 1;
  localparam int DISP_W   = COORD_BITS + 1;
  localparam int SQ_W     = 2 * COORD_BITS;
  localparam int SQ3_W    = SQ_W + 2;
  localparam int SUMSQ_W  = SQ3_W + IDX_W;
  localparam int SUMD_W   = DISP_W + IDX_W;
  localparam int MAG_W    = SUMD_W;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int NUM_A_W  = SUMSQ_W + CNT_W;
  localparam int NUM_B_W  = PROD_W + 2;
  localparam int NUM_W    = (NUM_A_W > NUM_B_W) ? NUM_A_W : NUM_B_W;
  localparam int DEN_W    = 2 * CNT_W;
  localparam int STEP_W   = $clog2(NUM_W + 1);
  localparam int REF_W    = 3 * COORD_BITS;
  localparam int NUM_AXES = 3;

  // Largest frame number before it wraps back to one.
  localparam logic [FRAME_W-1:0] FRAME_LAST = '1;

  // Register map: byte offset of each register, word aligned.
  localparam logic [APB_AW-1:0] REG_ATOM_COUNT = 3'd0;
  localparam logic [CFG_W-1:0]  ATOM_COUNT_RST = 13'd64;

  // Input beat.
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    start_run;
  } in_item_t;

  // Output beat.
  typedef struct packed {
    logic [MSD_W-1:0]   msd;
    logic [FRAME_W-1:0] frame_number;
  } out_item_t;

  // Frame totals handed to the end-of-frame unit.
  typedef struct packed {
    logic                     valid;
    logic [SUMSQ_W-1:0]       sum_sq;
    logic signed [SUMD_W-1:0] sum_x;
    logic signed [SUMD_W-1:0] sum_y;
    logic signed [SUMD_W-1:0] sum_z;
    logic [CNT_W-1:0]         k;
    logic [FRAME_W-1:0]       frame;
  } fin_load_t;

  // Finished result offered by the end-of-frame unit.
  typedef struct packed {
    logic      valid;
    logic      busy;
    out_item_t item;
  } fin_res_t;

endpackage

`default_nettype wire

// ----- src/cmsd_fin.sv -----
// End-of-frame unit: forms (k*S2 - |D|^2) / k^2 with shift-add multiplies
// and a restoring divider, one bit per cycle. Depends on cmsd_pkg.
`default_nettype none

module cmsd_fin import cmsd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire fin_load_t ld,
  input  wire logic      res_take,
  output fin_res_t       res
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MULK = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_SUB  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [STEP_W-1:0] K_LAST   = STEP_W'(CNT_W - 1);
  localparam logic [STEP_W-1:0] SQ_LAST  = STEP_W'(MAG_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(NUM_W - 1);
  localparam logic [1:0]        AXIS_LAST = 2'(NUM_AXES - 1);

  logic [2:0]         state_r;
  logic [STEP_W-1:0]  step_r;
  logic [1:0]         axis_r;
  logic [SUMSQ_W-1:0] sum_sq_r;
  logic [CNT_W-1:0]   kbits_r;
  logic [DEN_W-1:0]   den_r;
  logic [MAG_W-1:0]   mag_r [NUM_AXES];
  logic [MAG_W-1:0]   mbits_r;
  logic [PROD_W-1:0]  prod_r;
  logic [NUM_W-1:0]   num_r;
  logic [NUM_W-1:0]   dd_r;
  logic [DEN_W-1:0]   rem_r;
  logic [MSD_W-1:0]   quo_r;
  logic [FRAME_W-1:0] frame_r;

  logic [PROD_W-1:0]  prod_nxt;
  logic [DEN_W:0]     trial_nxt;

  // Magnitude of a signed displacement sum.
  function automatic logic [MAG_W-1:0] abs_sum(input logic signed [SUMD_W-1:0] v);
    logic signed [SUMD_W-1:0] n;
    n = -v;
    abs_sum = v[SUMD_W-1] ? MAG_W'(unsigned'(n)) : MAG_W'(unsigned'(v));
  endfunction

  // One shift-add step of a squaring, and one step of the long division.
  always_comb begin
    prod_nxt  = {prod_r[PROD_W-2:0], 1'b0}
              + (mbits_r[MAG_W-1] ? PROD_W'(mag_r[0]) : '0);
    trial_nxt = {rem_r, num_r[NUM_W-1]};
  end

  // Sequencer: multiply S2 by k, square the three sums, subtract, divide.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      axis_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (ld.valid) begin
            sum_sq_r <= ld.sum_sq;
            kbits_r  <= ld.k;
            den_r    <= DEN_W'(ld.k) * DEN_W'(ld.k);
            mag_r[0] <= abs_sum(ld.sum_x);
            mag_r[1] <= abs_sum(ld.sum_y);
            mag_r[2] <= abs_sum(ld.sum_z);
            frame_r  <= ld.frame;
            num_r    <= '0;
            dd_r     <= '0;
            step_r   <= '0;
            state_r  <= ST_MULK;
          end
        end
        ST_MULK: begin
          num_r   <= {num_r[NUM_W-2:0], 1'b0}
                   + (kbits_r[CNT_W-1] ? NUM_W'(sum_sq_r) : '0);
          kbits_r <= {kbits_r[CNT_W-2:0], 1'b0};
          if (step_r == K_LAST) begin
            step_r  <= '0;
            axis_r  <= '0;
            prod_r  <= '0;
            mbits_r <= mag_r[0];
            state_r <= ST_SQ;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_SQ: begin
          if (step_r == SQ_LAST) begin
            // Square of this axis is complete; move the next axis up.
            dd_r     <= dd_r + NUM_W'(prod_nxt);
            prod_r   <= '0;
            mag_r[0] <= mag_r[1];
            mag_r[1] <= mag_r[2];
            mbits_r  <= mag_r[1];
            step_r   <= '0;
            axis_r   <= axis_r + 1'b1;
            if (axis_r == AXIS_LAST) begin
              state_r <= ST_SUB;
            end
          end else begin
            prod_r  <= prod_nxt;
            mbits_r <= {mbits_r[MAG_W-2:0], 1'b0};
            step_r  <= step_r + 1'b1;
          end
        end
        ST_SUB: begin
          num_r   <= (num_r >= dd_r) ? (num_r - dd_r) : '0;
          rem_r   <= '0;
          quo_r   <= '0;
          step_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (trial_nxt >= {1'b0, den_r}) begin
            rem_r <= DEN_W'(trial_nxt - {1'b0, den_r});
            quo_r <= {quo_r[MSD_W-2:0], 1'b1};
          end else begin
            rem_r <= trial_nxt[DEN_W-1:0];
            quo_r <= {quo_r[MSD_W-2:0], 1'b0};
          end
          num_r <= {num_r[NUM_W-2:0], 1'b0};
          if (step_r == DIV_LAST) begin
            state_r <= ST_DONE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign res.valid             = (state_r == ST_DONE);
  assign res.busy              = (state_r != ST_IDLE);
  assign res.item.msd          = quo_r;
  assign res.item.frame_number = frame_r;

endmodule

`default_nettype wire

// ----- src/com_corrected_msd.sv -----
// Top level of the drift-corrected mean squared displacement block.
// Depends on cmsd_pkg and instantiates the end-of-frame unit cmsd_fin.
`default_nettype none

// The block takes one atom position per cycle while in_stall is low. The first
// frame after reset or after a beat with start_run set is stored in the
// reference memory (one entry per atom, written at the atom's index) and yields
// no result. Each later atom reads its reference entry, and the displacement,
// its squared length and the running sums pass through three pipeline stages
// behind the memory read. The last atom of a measured frame locks the input
// (in_stall high) while the pipeline drains and the end-of-frame unit forms the
// result bit-serially: the k*S2 product, then the three squared sums, then the
// subtraction and last the divide. Every other atom leaves the input open. The
// result waits in an output register, so the next frame may start streaming
// before the result is taken. atom_count is written through the APB port at
// offset 0; 0 acts as 1, and values above 4096 act as 4096.

module com_corrected_msd import cmsd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input channel.
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  // Result channel.
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  // Configuration register.
  logic [CFG_W-1:0] atom_count_r;

  // Frame sequencing state.
  logic [IDX_W-1:0]   atom_index_r;
  logic [FRAME_W-1:0] frame_ctr_r;
  logic               hold_r;

  // Reference memory and its registered read data.
  logic [REF_W-1:0] ref_mem [MAX_ATOMS];
  logic [REF_W-1:0] ref_rd_r;

  // Pipeline stages behind the memory read.
  logic                           s1_valid_r, s2_valid_r, s3_valid_r;
  logic                           s1_first_r, s2_first_r, s3_first_r;
  logic                           s1_last_r,  s2_last_r,  s3_last_r;
  logic [CNT_W-1:0]               s1_k_r,     s2_k_r,     s3_k_r;
  logic [FRAME_W-1:0]             s1_frame_r, s2_frame_r, s3_frame_r;
  logic signed [COORD_BITS-1:0]   s1_pos_r [NUM_AXES];
  logic signed [DISP_W-1:0]       s2_d_r   [NUM_AXES];
  logic signed [DISP_W-1:0]       s3_d_r   [NUM_AXES];
  logic [SQ_W-1:0]                s3_sq_r  [NUM_AXES];

  // Frame accumulators.
  logic signed [SUMD_W-1:0] acc_d_r [NUM_AXES];
  logic [SUMSQ_W-1:0]       acc_sq_r;

  // Hand-off to the end-of-frame unit.
  logic               go_r;
  logic [CNT_W-1:0]   go_k_r;
  logic [FRAME_W-1:0] go_frame_r;
  fin_load_t          fin_ld;
  fin_res_t           fin_res;

  // Output register.
  logic      out_valid_r;
  out_item_t out_data_r;

  // Accept-stage decode.
  logic                         in_acc;
  logic [IDX_W-1:0]             idx_eff;
  logic [FRAME_W-1:0]           frame_eff;
  logic [CNT_W-1:0]             n_eff;
  logic [CNT_W-1:0]             k_eff;
  logic                         last_eff;
  logic                         ref_frame;
  logic signed [COORD_BITS-1:0] pos_in [NUM_AXES];
  logic signed [DISP_W-1:0]     d_nxt  [NUM_AXES];
  logic [2*DISP_W-1:0]          prod_nxt [NUM_AXES];
  logic [SQ3_W-1:0]             sq3_nxt;
  logic                         out_take;
  logic                         cfg_wr;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = hold_r;

  // Coordinates keep their low COORD_BITS bits, sign-extended.
  assign pos_in[0] = $signed(in_data.pos_x[COORD_BITS-1:0]);
  assign pos_in[1] = $signed(in_data.pos_y[COORD_BITS-1:0]);
  assign pos_in[2] = $signed(in_data.pos_z[COORD_BITS-1:0]);

  // Effective frame position, clamped atom count and end-of-frame test.
  always_comb begin
    idx_eff   = in_data.start_run ? '0 : atom_index_r;
    frame_eff = in_data.start_run ? '0 : frame_ctr_r;
    if (atom_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(atom_count_r) > MAX_ATOMS) begin
      n_eff = CNT_W'(MAX_ATOMS);
    end else begin
      n_eff = CNT_W'(atom_count_r);
    end
    k_eff     = CNT_W'(idx_eff) + 1'b1;
    last_eff  = (k_eff >= n_eff);
    ref_frame = (frame_eff == '0);
  end

  // Configuration write and readback.
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr == REG_ATOM_COUNT) ? APB_DW'(atom_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atom_count_r <= ATOM_COUNT_RST;
    end else if (cfg_wr && (paddr == REG_ATOM_COUNT)) begin
      atom_count_r <= pwdata[CFG_W-1:0];
    end
  end

  // Frame sequencing; the last atom of a measured frame locks the input.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atom_index_r <= '0;
      frame_ctr_r  <= '0;
      hold_r       <= 1'b0;
    end else begin
      if (in_acc) begin
        atom_index_r <= last_eff ? '0 : k_eff[IDX_W-1:0];
        if (ref_frame) begin
          frame_ctr_r <= last_eff ? FRAME_W'(1) : '0;
        end else if (last_eff) begin
          frame_ctr_r <= (frame_eff == FRAME_LAST) ? FRAME_W'(1) : frame_eff + 1'b1;
          hold_r      <= 1'b1;
        end else begin
          frame_ctr_r <= frame_eff;
        end
      end else if (out_take) begin
        hold_r <= 1'b0;
      end
    end
  end

  // Reference memory: written during the reference frame, read on every accepted beat.
  always_ff @(posedge clk) begin
    if (in_acc && ref_frame) begin
      ref_mem[idx_eff] <= {pos_in[0], pos_in[1], pos_in[2]};
    end
    if (in_acc) begin
      ref_rd_r <= ref_mem[idx_eff];
    end
  end

  // Displacement from the reference position, then its square.
  always_comb begin
    d_nxt[0] = DISP_W'(s1_pos_r[0]) - DISP_W'($signed(ref_rd_r[3*COORD_BITS-1:2*COORD_BITS]));
    d_nxt[1] = DISP_W'(s1_pos_r[1]) - DISP_W'($signed(ref_rd_r[2*COORD_BITS-1:COORD_BITS]));
    d_nxt[2] = DISP_W'(s1_pos_r[2]) - DISP_W'($signed(ref_rd_r[COORD_BITS-1:0]));
    for (int a = 0; a < NUM_AXES; a++) begin
      prod_nxt[a] = s2_d_r[a] * s2_d_r[a];
    end
    sq3_nxt = SQ3_W'(s3_sq_r[0]) + SQ3_W'(s3_sq_r[1]) + SQ3_W'(s3_sq_r[2]);
  end

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      go_r       <= 1'b0;
    end else begin
      s1_valid_r <= in_acc && !ref_frame;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      go_r       <= s3_valid_r && s3_last_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    s1_first_r <= (idx_eff == '0);
    s1_last_r  <= last_eff;
    s1_k_r     <= k_eff;
    s1_frame_r <= frame_eff;
    for (int a = 0; a < NUM_AXES; a++) begin
      s1_pos_r[a] <= pos_in[a];
      s2_d_r[a]   <= d_nxt[a];
      s3_d_r[a]   <= s2_d_r[a];
      s3_sq_r[a]  <= prod_nxt[a][SQ_W-1:0];
    end
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_k_r     <= s1_k_r;
    s2_frame_r <= s1_frame_r;
    s3_first_r <= s2_first_r;
    s3_last_r  <= s2_last_r;
    s3_k_r     <= s2_k_r;
    s3_frame_r <= s2_frame_r;
    go_k_r     <= s3_k_r;
    go_frame_r <= s3_frame_r;
  end

  // Accumulators restart with the first atom of each measured frame.
  always_ff @(posedge clk) begin
    if (s3_valid_r) begin
      if (s3_first_r) begin
        acc_sq_r <= SUMSQ_W'(sq3_nxt);
        for (int a = 0; a < NUM_AXES; a++) begin
          acc_d_r[a] <= SUMD_W'(s3_d_r[a]);
        end
      end else begin
        acc_sq_r <= acc_sq_r + SUMSQ_W'(sq3_nxt);
        for (int a = 0; a < NUM_AXES; a++) begin
          acc_d_r[a] <= acc_d_r[a] + SUMD_W'(s3_d_r[a]);
        end
      end
    end
  end

  // Frame totals go to the end-of-frame unit.
  assign fin_ld.valid  = go_r;
  assign fin_ld.sum_sq = acc_sq_r;
  assign fin_ld.sum_x  = acc_d_r[0];
  assign fin_ld.sum_y  = acc_d_r[1];
  assign fin_ld.sum_z  = acc_d_r[2];
  assign fin_ld.k      = go_k_r;
  assign fin_ld.frame  = go_frame_r;

  cmsd_fin u_fin (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (fin_ld),
    .res_take (out_take),
    .res      (fin_res)
  );

  // Output register.
  assign out_take = fin_res.valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_data_r <= fin_res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The input stays locked for as long as a frame result is being formed.
  a_hold_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fin_res.busy |-> hold_r)
    else $error("end-of-frame unit busy while input is open");

  // The pipeline is empty whenever the end-of-frame unit is working.
  a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fin_res.busy |-> !(s1_valid_r || s2_valid_r || s3_valid_r || go_r))
    else $error("atom in flight during end-of-frame work");

  // A frame end only reaches the unit while the input is locked and the unit is idle.
  a_go_locked: assert property (@(posedge clk) disable iff (!rst_n)
    go_r |-> (hold_r && !fin_res.busy))
    else $error("frame end handed over outside a locked, idle state");

  // A result is offered only while the input is still locked for it.
  a_result_locked: assert property (@(posedge clk) disable iff (!rst_n)
    fin_res.valid |-> hold_r)
    else $error("result pending with the input open");

endmodule

`default_nettype wire
